/* rtl/swrb_pkg.sv */
package swrb_pkg;

	// field widths
	localparam int OP_W     = 3;
	localparam int SEQ_W    = 32;
	localparam int OFF_W    = 11;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 11;
	localparam int VAL_W    = 31;
	localparam int WIN_W    = 5;

	// modulo unit: dividend bits taken per step and number of steps per item
	localparam int DIGIT_BITS = 4;
	localparam int MOD_STEPS  = SEQ_W / DIGIT_BITS;
	localparam int STEP_CNT_W = $clog2(MOD_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE      = 3'd0,
		OP_READ       = 3'd1,
		OP_CHECK      = 3'd2,
		OP_INVAL      = 3'd3,
		OP_RAISE_EXP  = 3'd4,
		OP_RAISE_HIGH = 3'd5
	} opcode_t;

endpackage

/* rtl/swrb_ram.sv */
module swrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/swrb_mod.sv */
module swrb_mod #(
	parameter int WINDOW_MAX = 16,
	localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int DIV_W = SLOT_W + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swrb_pkg::SEQ_W-1:0] dividend,
	input  logic [DIV_W-1:0]           divisor,
	output logic                       done,
	output logic [SLOT_W-1:0]          remainder
);

	import swrb_pkg::*;

	logic                  run_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [SEQ_W-1:0]      dvd_q;
	logic [SLOT_W-1:0]     rem_q;
	logic [SLOT_W-1:0]     rem_next;
	logic [DIV_W-1:0]      part;
	logic [DIV_W-1:0]      trial;

	// one digit of the remainder: for each of its bits, shift it in and subtract once if too large
	always_comb begin
		part = DIV_W'(rem_q);
		trial = '0;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			trial = {part[SLOT_W-1:0], dvd_q[SEQ_W-1-i]};
			part = (trial >= divisor) ? (trial - divisor) : trial;
		end
		rem_next = part[SLOT_W-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_CNT_W'(1);
				if (cnt_q == STEP_CNT_W'(MOD_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifter and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << DIGIT_BITS;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

/* rtl/sliding_window_receive_buffer.sv */
// channel   | handshake                  | beat
// ----------+----------------------------+-------------------------------------------
// command   | start, busy                | opcode, seq_number, byte_offset,
//           |                            | write_byte, pdu_length, last_byte, update_value
// result    | done (one-cycle strobe)    | status, read_byte, stored_length, slot_valid,
//           |                            | expected_value, highest_value, buffer_empty
// config    | cfg_valid, cfg_ready       | cfg_data (window size)
//
// a command beat holds busy while the slot index comes from a 4-bit-per-cycle
// remainder unit (ST_DIV), then the payload and length memories are accessed
// (ST_MEM) and the result is formed (ST_RESP); done follows.
// result is registered and shown for one cycle; the receiver cannot stall it.
// reset clears the valid marks, count, maxima and window (to 1); memories are not
// cleared. cfg_ready is low while busy. a window write clears all valid marks.
module sliding_window_receive_buffer #(
	parameter int WINDOW_MAX = 16,
	parameter int SLOT_BYTES = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [swrb_pkg::OP_W-1:0]   opcode,
	input  logic [swrb_pkg::SEQ_W-1:0]  seq_number,
	input  logic [swrb_pkg::OFF_W-1:0]  byte_offset,
	input  logic [swrb_pkg::BYTE_W-1:0] write_byte,
	input  logic [swrb_pkg::LEN_W-1:0]  pdu_length,
	input  logic                        last_byte,
	input  logic [swrb_pkg::VAL_W-1:0]  update_value,
	output logic                        done,
	output logic                        status,
	output logic [swrb_pkg::BYTE_W-1:0] read_byte,
	output logic [swrb_pkg::LEN_W-1:0]  stored_length,
	output logic                        slot_valid,
	output logic [swrb_pkg::VAL_W-1:0]  expected_value,
	output logic [swrb_pkg::VAL_W-1:0]  highest_value,
	output logic                        buffer_empty,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [swrb_pkg::WIN_W-1:0]  cfg_data
);

	import swrb_pkg::*;

	localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int DIV_W  = SLOT_W + 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int PAY_DEPTH = WINDOW_MAX * SLOT_BYTES;
	localparam int PAY_AW = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MEM,
		ST_RESP
	} state_t;

	state_t              state_q;
	logic [DIV_W-1:0]    eff_win_q;
	logic [WINDOW_MAX-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [VAL_W-1:0]    expected_q;
	logic [VAL_W-1:0]    highest_q;

	logic                done_q;
	logic                status_q;
	logic [BYTE_W-1:0]   read_byte_q;
	logic [LEN_W-1:0]    stored_length_q;
	logic                slot_valid_q;
	logic                empty_q;

	// captured command beat
	logic [OP_W-1:0]     op_q;
	logic [OFF_W-1:0]    off_q;
	logic                off_ok_q;
	logic [BYTE_W-1:0]   wbyte_q;
	logic [LEN_W-1:0]    plen_q;
	logic                last_q;
	logic [VAL_W-1:0]    upd_q;

	logic                accept;
	logic                cfg_write;
	logic                mod_done;
	logic [SLOT_W-1:0]   slot;
	logic                cur_valid;

	logic                pay_en;
	logic                pay_we;
	logic [PAY_AW-1:0]   pay_addr;
	logic [BYTE_W-1:0]   pay_rdata;
	logic                len_en;
	logic                len_we;
	logic [LEN_W-1:0]    len_rdata;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cur_valid = valid_q[slot];

	// slot index = seq_number mod window
	swrb_mod #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (seq_number),
		.divisor  (eff_win_q),
		.done     (mod_done),
		.remainder(slot)
	);

	// memory access in the access cycle
	always_comb begin
		pay_en = 1'b0;
		pay_we = 1'b0;
		len_en = 1'b0;
		len_we = 1'b0;
		if (state_q == ST_MEM) begin
			unique case (opcode_t'(op_q))
				OP_WRITE: begin
					pay_en = off_ok_q;
					pay_we = 1'b1;
					len_en = last_q;
					len_we = 1'b1;
				end
				OP_READ: begin
					pay_en = off_ok_q && cur_valid;
					len_en = cur_valid;
				end
				default: begin
				end
			endcase
		end
	end

	assign pay_addr = PAY_AW'(slot) * PAY_AW'(SLOT_BYTES) + PAY_AW'(off_q);

	swrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PAY_DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.en   (pay_en),
		.we   (pay_we),
		.addr (pay_addr),
		.wdata(wbyte_q),
		.rdata(pay_rdata)
	);

	swrb_ram #(
		.WIDTH(LEN_W),
		.DEPTH(WINDOW_MAX)
	) u_length_ram (
		.clk  (clk),
		.en   (len_en),
		.we   (len_we),
		.addr (slot),
		.wdata(plen_q),
		.rdata(len_rdata)
	);

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			off_q <= byte_offset;
			off_ok_q <= (32'(byte_offset) < 32'(SLOT_BYTES));
			wbyte_q <= write_byte;
			plen_q <= pdu_length;
			last_q <= last_byte;
			upd_q <= update_value;
		end
	end

	// sequencer, slot marks, maxima and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eff_win_q <= DIV_W'(1);
			valid_q <= '0;
			count_q <= '0;
			expected_q <= '0;
			highest_q <= '0;
			done_q <= 1'b0;
			status_q <= 1'b0;
			read_byte_q <= '0;
			stored_length_q <= '0;
			slot_valid_q <= 1'b0;
			empty_q <= 1'b1;
		end else begin
			done_q <= 1'b0;

			// window write clamps the size and starts the window afresh
			if (cfg_write) begin
				if (cfg_data == '0) begin
					eff_win_q <= DIV_W'(1);
				end else if (32'(cfg_data) > 32'(WINDOW_MAX)) begin
					eff_win_q <= DIV_W'(WINDOW_MAX);
				end else begin
					eff_win_q <= DIV_W'(cfg_data);
				end
				valid_q <= '0;
				count_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					state_q <= ST_RESP;
					unique case (opcode_t'(op_q))
						OP_WRITE: begin
							if (last_q && !cur_valid) begin
								valid_q[slot] <= 1'b1;
								count_q <= count_q + CNT_W'(1);
							end
						end
						OP_INVAL: begin
							if (cur_valid) begin
								valid_q[slot] <= 1'b0;
								count_q <= count_q - CNT_W'(1);
							end
						end
						OP_RAISE_EXP: begin
							if (upd_q > expected_q) begin
								expected_q <= upd_q;
							end
						end
						OP_RAISE_HIGH: begin
							if (upd_q > highest_q) begin
								highest_q <= upd_q;
							end
						end
						default: begin
						end
					endcase
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
					status_q <= (opcode_t'(op_q) == OP_READ) && !cur_valid;
					read_byte_q <= ((opcode_t'(op_q) == OP_READ) && cur_valid && off_ok_q)
						? pay_rdata : '0;
					stored_length_q <= ((opcode_t'(op_q) == OP_READ) && cur_valid)
						? len_rdata : '0;
					slot_valid_q <= cur_valid;
					empty_q <= (count_q == '0);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign read_byte = read_byte_q;
	assign stored_length = stored_length_q;
	assign slot_valid = slot_valid_q;
	assign expected_value = expected_q;
	assign highest_value = highest_q;
	assign buffer_empty = empty_q;

endmodule

/* verif/tb_sliding_window_receive_buffer.sv */
module tb_sliding_window_receive_buffer;

	import swrb_pkg::*;

	localparam int WINDOW_MAX  = 16;
	localparam int SLOT_BYTES  = 2048;
	localparam int STALL_LIMIT = 2000;

	// opcodes with no function, they report like check valid
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SEQ_W-1:0]  seq;
		logic [OFF_W-1:0]  off;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              last;
		logic [VAL_W-1:0]  upd;
	} buf_cmd_t;

	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] rbyte;
		logic [LEN_W-1:0]  rlen;
		logic              valid;
		logic [VAL_W-1:0]  exp_v;
		logic [VAL_W-1:0]  high_v;
		logic              empty;
	} buf_res_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              busy;
	logic [OP_W-1:0]   opcode       = '0;
	logic [SEQ_W-1:0]  seq_number   = '0;
	logic [OFF_W-1:0]  byte_offset  = '0;
	logic [BYTE_W-1:0] write_byte   = '0;
	logic [LEN_W-1:0]  pdu_length   = '0;
	logic              last_byte    = 1'b0;
	logic [VAL_W-1:0]  update_value = '0;
	logic              done;
	logic              status;
	logic [BYTE_W-1:0] read_byte;
	logic [LEN_W-1:0]  stored_length;
	logic              slot_valid;
	logic [VAL_W-1:0]  expected_value;
	logic [VAL_W-1:0]  highest_value;
	logic              buffer_empty;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [WIN_W-1:0]  cfg_data     = '0;

	sliding_window_receive_buffer #(
		.WINDOW_MAX(WINDOW_MAX),
		.SLOT_BYTES(SLOT_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.seq_number    (seq_number),
		.byte_offset   (byte_offset),
		.write_byte    (write_byte),
		.pdu_length    (pdu_length),
		.last_byte     (last_byte),
		.update_value  (update_value),
		.done          (done),
		.status        (status),
		.read_byte     (read_byte),
		.stored_length (stored_length),
		.slot_valid    (slot_valid),
		.expected_value(expected_value),
		.highest_value (highest_value),
		.buffer_empty  (buffer_empty),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// window state mirror
	logic [BYTE_W-1:0] win_bytes [WINDOW_MAX][SLOT_BYTES];
	bit                byte_seen [WINDOW_MAX][SLOT_BYTES];
	int unsigned       seen_offs [WINDOW_MAX][$];
	logic [LEN_W-1:0]  win_len   [WINDOW_MAX];
	bit                win_valid [WINDOW_MAX];
	int unsigned       valid_cnt = 0;
	logic [VAL_W-1:0]  exp_max   = '0;
	logic [VAL_W-1:0]  high_max  = '0;
	logic [WIN_W-1:0]  win_cfg   = 5'd1;

	buf_res_t    pending_results[$];
	int unsigned mismatch_cnt = 0;
	int unsigned items_sent   = 0;
	int unsigned calm_left    = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_window();
		if (win_cfg == 0)
			return 1;
		if (win_cfg > WINDOW_MAX)
			return WINDOW_MAX;
		return 32'(win_cfg);
	endfunction

	// next result of the buffer for one command, state advanced
	function automatic buf_res_t predict_result(input buf_cmd_t c);
		buf_res_t    r;
		int unsigned slot;
		slot = c.seq % eff_window();
		r = '0;
		case (c.op)
			OP_WRITE: begin
				if (c.off < SLOT_BYTES) begin
					win_bytes[slot][c.off] = c.data;
					if (!byte_seen[slot][c.off]) begin
						byte_seen[slot][c.off] = 1'b1;
						seen_offs[slot].push_back(32'(c.off));
					end
				end
				if (c.last) begin
					win_len[slot] = c.len;
					if (!win_valid[slot]) begin
						win_valid[slot] = 1'b1;
						valid_cnt++;
					end
				end
			end
			OP_READ: begin
				if (!win_valid[slot]) begin
					r.status = 1'b1;
				end else begin
					r.rbyte = (c.off < SLOT_BYTES) ? win_bytes[slot][c.off] : '0;
					r.rlen  = win_len[slot];
				end
			end
			OP_INVAL: begin
				if (win_valid[slot]) begin
					win_valid[slot] = 1'b0;
					valid_cnt--;
				end
			end
			OP_RAISE_EXP: begin
				if (c.upd > exp_max)
					exp_max = c.upd;
			end
			OP_RAISE_HIGH: begin
				if (c.upd > high_max)
					high_max = c.upd;
			end
			default: ;
		endcase
		r.valid  = win_valid[slot];
		r.exp_v  = exp_max;
		r.high_v = high_max;
		r.empty  = (valid_cnt == 0);
		return r;
	endfunction

	function automatic buf_cmd_t rand_cmd(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq);
		buf_cmd_t c;
		c.op   = op;
		c.seq  = seq;
		c.off  = OFF_W'($urandom);
		c.data = BYTE_W'($urandom);
		c.len  = LEN_W'($urandom);
		c.last = 1'($urandom);
		c.upd  = VAL_W'($urandom);
		return c;
	endfunction

	// sequence number that mostly lands on a slot holding a valid packet
	function automatic logic [SEQ_W-1:0] aim_seq();
		int               live[$];
		int               s;
		longint unsigned  w;
		longint unsigned  v;
		for (int i = 0; i < WINDOW_MAX; i++)
			if (win_valid[i])
				live.push_back(i);
		if (live.size() == 0 || $urandom_range(0, 3) == 0)
			return $urandom;
		s = live[$urandom_range(0, live.size() - 1)];
		w = 64'(eff_window());
		v = 64'($urandom);
		v = (v / w) * w + 64'(s);
		if (v > 64'hFFFF_FFFF)
			v -= w;
		return v[SEQ_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] raise_candidate(input logic [VAL_W-1:0] cur);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return VAL_W'(32'(cur) + $urandom_range(1, 500));
		if (r < 75)
			return VAL_W'(32'(cur) - $urandom_range(0, 500));
		if (r < 90)
			return VAL_W'($urandom >> $urandom_range(1, 31));
		return VAL_W'($urandom);
	endfunction

	task automatic log_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want)
			log_mismatch($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	// one command beat with a random lead-in gap
	task automatic send_cmd(input buf_cmd_t c);
		int unsigned gap;
		int unsigned r;
		if ($urandom_range(0, 63) == 0)
			wait_drained();
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(20, 60);
			r = $urandom_range(0, 99);
			if (r < 60)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(5, 40);
		end
		repeat (gap + 1) @(posedge clk);
		start        <= 1'b1;
		opcode       <= c.op;
		seq_number   <= c.seq;
		byte_offset  <= c.off;
		write_byte   <= c.data;
		pdu_length   <= c.len;
		last_byte    <= c.last;
		update_value <= c.upd;
		do @(posedge clk); while (busy !== 1'b0);
		start <= 1'b0;
		pending_results.push_back(predict_result(c));
		items_sent++;
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [OFF_W-1:0] off);
		buf_cmd_t c;
		c = rand_cmd(op, seq);
		c.off = off;
		send_cmd(c);
	endtask

	task automatic send_write(input logic [SEQ_W-1:0] seq, input logic [OFF_W-1:0] off,
			input logic [BYTE_W-1:0] data, input logic last, input logic [LEN_W-1:0] len);
		buf_cmd_t c;
		c = rand_cmd(OP_WRITE, seq);
		c.off  = off;
		c.data = data;
		c.last = last;
		c.len  = len;
		send_cmd(c);
	endtask

	task automatic send_raise(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
		buf_cmd_t c;
		c = rand_cmd(op, $urandom);
		c.upd = v;
		send_cmd(c);
	endtask

	// window size write, only with the buffer idle
	task automatic write_window(input logic [WIN_W-1:0] w);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		win_cfg = w;
		valid_cnt = 0;
		for (int i = 0; i < WINDOW_MAX; i++)
			win_valid[i] = 1'b0;
	endtask

	// packet written byte by byte, sometimes cut short, then sometimes read back
	task automatic send_packet();
		int unsigned      n;
		int unsigned      base;
		int unsigned      r;
		bit               cut;
		buf_cmd_t         c;
		logic [SEQ_W-1:0] seq;
		n = $urandom_range(1, 6);
		r = $urandom_range(0, 99);
		if (r < 70)
			base = $urandom_range(0, 60);
		else if (r < 85)
			base = SLOT_BYTES - n;
		else
			base = $urandom_range(0, SLOT_BYTES - n);
		seq = (win_valid[0] || $urandom_range(0, 1)) ? $urandom : aim_seq();
		cut = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < n; i++) begin
			c = rand_cmd(OP_WRITE, seq);
			c.off  = OFF_W'(base + i);
			c.last = (i == n - 1) && !cut;
			if ($urandom_range(0, 3) != 0)
				c.len = LEN_W'(n);
			send_cmd(c);
		end
		repeat ($urandom_range(0, 3))
			send_op(OP_READ, seq, OFF_W'(base + $urandom_range(0, n - 1)));
		if ($urandom_range(0, 9) < 3)
			send_op(OP_INVAL, seq, OFF_W'($urandom));
	endtask

	task automatic send_random_op();
		int unsigned      r;
		int unsigned      slot;
		logic [SEQ_W-1:0] seq;
		logic [OFF_W-1:0] off;
		r = $urandom_range(0, 99);
		seq = aim_seq();
		slot = seq % eff_window();
		if (r < 35) begin
			// a valid slot is only read where a byte was stored
			if (win_valid[slot])
				off = OFF_W'(seen_offs[slot][$urandom_range(0, seen_offs[slot].size() - 1)]);
			else
				off = OFF_W'($urandom);
			send_op(OP_READ, seq, off);
		end else if (r < 44) begin
			send_op(OP_CHECK, seq, OFF_W'($urandom));
		end else if (r < 50) begin
			send_op($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, seq, OFF_W'($urandom));
		end else if (r < 65) begin
			send_op(OP_INVAL, seq, OFF_W'($urandom));
		end else if (r < 80) begin
			send_raise(OP_RAISE_EXP, raise_candidate(exp_max));
		end else begin
			send_raise(OP_RAISE_HIGH, raise_candidate(high_max));
		end
	endtask

	task automatic run_random_traffic(input int unsigned n);
		int unsigned stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 55)
				send_packet();
			else
				send_random_op();
		end
	endtask

	// tests

	task automatic test_reset_state();
		send_op(OP_CHECK, 32'd0, 11'd0);
		send_op(OP_READ, 32'hFFFF_FFFF, 11'd0);
		send_op(OP_INVAL, 32'd5, 11'd0);
		send_op(OP_SPARE_A, 32'd123, 11'd0);
		send_op(OP_SPARE_B, 32'hFFFF_FFFF, 11'h7FF);
	endtask

	task automatic test_basic_ops();
		write_window(5'd4);
		// slot 3 filled at both ends of its payload
		send_write(32'hFFFF_FFFF, 11'h7FF, 8'hFF, 1'b0, 11'd0);
		send_write(32'd3, 11'd0, 8'h00, 1'b1, 11'h7FF);
		send_op(OP_READ, 32'd7, 11'h7FF);
		send_op(OP_READ, 32'hFFFF_FFFF, 11'd0);
		// last byte again on a valid slot: new length, same count
		send_write(32'd3, 11'd5, 8'hA5, 1'b1, 11'd0);
		send_op(OP_READ, 32'd3, 11'd5);
		send_op(OP_READ, 32'd11, 11'h7FF);
		send_write(32'd0, 11'd1, 8'h5A, 1'b1, 11'd1);
		send_op(OP_INVAL, 32'd4, 11'd0);
		send_op(OP_INVAL, 32'd8, 11'd0);
		send_op(OP_READ, 32'd8, 11'd1);
		// running maxima take strictly larger values only
		send_raise(OP_RAISE_EXP, 31'd100);
		send_raise(OP_RAISE_EXP, 31'd99);
		send_raise(OP_RAISE_EXP, 31'd0);
		send_raise(OP_RAISE_HIGH, 31'h4000_0000);
		send_raise(OP_RAISE_HIGH, 31'h3FFF_FFFF);
	endtask

	task automatic test_window_rewrite();
		write_window(5'd4);
		send_op(OP_CHECK, 32'd3, 11'd0);
		send_op(OP_READ, 32'd3, 11'd0);
	endtask

	task automatic test_window_limits();
		logic [WIN_W-1:0] sizes[5];
		sizes = '{5'd0, 5'd31, 5'd17, 5'd16, 5'd1};
		foreach (sizes[i]) begin
			write_window(sizes[i]);
			run_random_traffic(60);
		end
	endtask

	task automatic test_random_traffic();
		logic [WIN_W-1:0] w;
		repeat (8) begin
			if ($urandom_range(0, 4) == 0)
				w = WIN_W'($urandom_range(0, 31));
			else
				w = WIN_W'($urandom_range(1, 16));
			write_window(w);
			run_random_traffic(200);
		end
	endtask

	task automatic test_maxima_ceiling();
		send_raise(OP_RAISE_EXP, 31'h7FFF_FFFF);
		send_raise(OP_RAISE_EXP, 31'h7FFF_FFFE);
		send_raise(OP_RAISE_HIGH, 31'h7FFF_FFFF);
		send_raise(OP_RAISE_HIGH, 31'h7FFF_FFFE);
	endtask

	// result check against the oldest pending prediction
	always @(posedge clk) begin : result_check
		buf_res_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				log_mismatch("result beat with no command pending");
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("read_byte", 32'(want.rbyte), 32'(read_byte));
				check_field("stored_length", 32'(want.rlen), 32'(stored_length));
				check_field("slot_valid", 32'(want.valid), 32'(slot_valid));
				check_field("expected_value", 32'(want.exp_v), 32'(expected_value));
				check_field("highest_value", 32'(want.high_v), 32'(highest_value));
				check_field("buffer_empty", 32'(want.empty), 32'(buffer_empty));
			end
		end
	end

	// stall watchdog
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_sliding_window_receive_buffer: errors");
		$finish;
	end

	// test sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_basic_ops();
		test_window_rewrite();
		test_window_limits();
		test_random_traffic();
		test_maxima_ceiling();
		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("tb_sliding_window_receive_buffer: clean");
		else
			$display("tb_sliding_window_receive_buffer: errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/swrb_pkg.sv
rtl/swrb_ram.sv
rtl/swrb_mod.sv
rtl/sliding_window_receive_buffer.sv
verif/tb_sliding_window_receive_buffer.sv
